// ===== sv/iirl_pkg.sv =====
// ----------------------------------------------------------------------------
// iirl_pkg
// Shared types and constants of the indexed insert/remove list core.
// ----------------------------------------------------------------------------
package iirl_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 256;
   localparam int CAP_W               = 9;
   localparam int POS_W               = 8;
   localparam int VALUE_W             = 64;
   localparam int COUNT_OUT_W         = 9;
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 9'd8;

   typedef enum logic [2:0] {
      OP_GET    = 3'd0,
      OP_SET    = 3'd1,
      OP_PUSH   = 3'd2,
      OP_POP    = 3'd3,
      OP_INSERT = 3'd4,
      OP_REMOVE = 3'd5,
      OP_CLEAR  = 3'd6,
      OP_NONE   = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic set_en;
      logic push_en;
      logic ins_en;
      logic rem_en;
   } cell_cmd_type;

endpackage

// ===== sv/iirl_cell.sv =====
// ----------------------------------------------------------------------------
// iirl_cell
// One storage cell of the list. Loads a new word, takes its left neighbor on
// an insert or its right neighbor on a remove, or holds.
// ----------------------------------------------------------------------------
module iirl_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 9
) (
   input  logic                          clock,
   input  iirl_pkg::cell_cmd_type        cmd,
   input  logic [CNT_W-1:0]              pos,
   input  logic [CNT_W-1:0]              count,
   input  logic [iirl_pkg::VALUE_W-1:0]  new_value,
   input  logic [iirl_pkg::VALUE_W-1:0]  left_value,
   input  logic [iirl_pkg::VALUE_W-1:0]  right_value,
   output logic [iirl_pkg::VALUE_W-1:0]  value
);
   import iirl_pkg::*;

   localparam logic [CNT_W-1:0] IDX    = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(INDEX + 1);

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if ((cmd.set_en || cmd.ins_en) && (IDX == pos)) begin
         value_in = new_value;
      end else if (cmd.push_en && (IDX == count)) begin
         value_in = new_value;
      end else if (cmd.ins_en && (IDX > pos) && (IDX <= count)) begin
         value_in = left_value;
      end else if (cmd.rem_en && (IDX >= pos) && (IDX_P1 < count)) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== sv/indexed_insert_remove_list_core.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_core
// Ordered list of 64-bit words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage: a request word on the req_ channel carries mode, position and a
// value; it is taken at a clock edge where req_valid is high and req_stall is
// low. Every request gives exactly one response word on the rsp_ channel,
// taken where rsp_valid is high and rsp_stall is low.
// The response is registered at the edge that takes the request.
// Throughput is one request per cycle while no response waits under rsp_stall; each
// cell of the row updates at that same edge, so insert and remove shift the whole list at once.
// While a response waits under rsp_stall, req_stall is high and new
// requests wait; the response word holds steady until it is taken.
// The capacity register is written over the csr_ channel (csr_ready is
// always high) and should only change while no request is in flight.
// Synchronous reset empties the list, sets the capacity to 8 and drops
// rsp_valid. Storage contents are not cleared; entries beyond the count
// cannot be read.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_core #(
   parameter int MAX_ENTRIES = iirl_pkg::MAX_ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_mode,
   input  logic [iirl_pkg::POS_W-1:0]        req_position,
   input  logic [iirl_pkg::VALUE_W-1:0]      req_entry_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [iirl_pkg::VALUE_W-1:0]      rsp_read_value,
   output logic                              rsp_read_valid,
   output logic [1:0]                        rsp_status,
   output logic [iirl_pkg::COUNT_OUT_W-1:0]  rsp_entry_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [iirl_pkg::CAP_W-1:0]        csr_data
);
   import iirl_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CAP_W-1:0]        cap_ff;
   logic                    rsp_valid_ff;
   logic [VALUE_W-1:0]      read_value_ff, read_value_in;
   logic                    read_valid_ff, read_valid_in;
   status_type              status_ff, status_in;

   logic                    req_fire;
   mode_type                mode;
   logic [CW-1:0]           cap_wide, cap_lim;
   logic                    full;
   logic [PW-1:0]           pos_wide, count_pwide;
   logic                    pos_lt_count, pos_le_count;
   logic [CNT_W-1:0]        pos_c;
   logic [IDX_W-1:0]        rd_addr;
   logic [CNT_W-1:0]        count_m1;
   cell_cmd_type            cmd;
   logic [VALUE_W-1:0]      cell_value [MAX_ENTRIES];

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign csr_ready = 1'b1;
   assign mode      = mode_type'(req_mode);

   assign cap_wide    = CW'(cap_ff);
   assign cap_lim     = (cap_wide > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : cap_wide;
   assign full        = CW'(count_ff) >= cap_lim;
   assign pos_wide    = PW'(req_position);
   assign count_pwide = PW'(count_ff);
   assign pos_lt_count = pos_wide < count_pwide;
   assign pos_le_count = pos_wide <= count_pwide;
   assign pos_c       = CNT_W'(req_position);
   assign count_m1    = count_ff - CNT_W'(1);
   assign rd_addr     = (mode == OP_POP) ? IDX_W'(count_m1) : IDX_W'(req_position);

   always_comb begin
      cmd           = '0;
      count_in      = count_ff;
      read_value_in = '0;
      read_valid_in = 1'b0;
      status_in     = ST_OK;
      unique case (mode)
         OP_GET: begin
            if (pos_lt_count) begin
               read_value_in = cell_value[rd_addr];
               read_valid_in = 1'b1;
            end else begin
               status_in = ST_RANGE;
            end
         end
         OP_SET: begin
            if (pos_lt_count) begin
               cmd.set_en = 1'b1;
            end else begin
               status_in = ST_RANGE;
            end
         end
         OP_PUSH: begin
            if (!full) begin
               cmd.push_en = 1'b1;
               count_in    = count_ff + CNT_W'(1);
            end else begin
               status_in = ST_FULL;
            end
         end
         OP_POP: begin
            if (count_ff != '0) begin
               count_in      = count_m1;
               read_value_in = cell_value[rd_addr];
               read_valid_in = 1'b1;
            end else begin
               status_in = ST_EMPTY;
            end
         end
         OP_INSERT: begin
            if (!pos_le_count) begin
               status_in = ST_RANGE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.ins_en = 1'b1;
               count_in   = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (pos_lt_count) begin
               cmd.rem_en = 1'b1;
               count_in   = count_m1;
            end else begin
               status_in = ST_RANGE;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
      if (!req_fire) begin
         cmd      = '0;
         count_in = count_ff;
      end
   end

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      iirl_cell #(
         .INDEX (g),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .pos         (pos_c),
         .count       (count_ff),
         .new_value   (req_entry_value),
         .left_value  (cell_value[(g == 0) ? 0 : g - 1]),
         .right_value (cell_value[(g == MAX_ENTRIES - 1) ? g : g + 1]),
         .value       (cell_value[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         read_value_ff <= read_value_in;
         read_valid_ff <= read_valid_in;
         status_ff     <= status_in;
      end
   end

   logic [COUNT_OUT_W-1:0] count_out_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         count_out_ff <= COUNT_OUT_W'(count_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = read_value_ff;
   assign rsp_read_valid  = read_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_out_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(MAX_ENTRIES) >= count_ff)
      else $error("entry count exceeds storage");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted request gave no response");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (mode == OP_PUSH) && !full) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("push did not grow the list");

   a_read_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && read_valid_ff) |-> (status_ff == ST_OK))
      else $error("read word flagged with error status");

endmodule
